/* sv/best_fit_block_allocator_unit_defines.svh */
// Assertion macros for the best-fit block allocator.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfa assertion failed");
`define BFA_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("bfa assertion failed");
`else
`define BFA_ASSERT(lbl, prop)
`define BFA_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

/* sv/bfa_pkg.sv */
// Types and constants shared by the best-fit block allocator.
package bfa_pkg;
  localparam int HEAP_BYTES   = 65536;
  localparam int FREE_ENTRIES = 64;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int SPLIT_FACTOR = 2;
  localparam int OFS_W   = 16;
  localparam int SIZE_W  = 17;
  localparam int CNT_W   = $clog2(FREE_ENTRIES + 1);
  localparam int ADDR_W  = $clog2(FREE_ENTRIES);
  localparam int SLOT_W  = $clog2(HEAP_BYTES / ALIGN_BYTES);
  localparam int ALIGN_W = $clog2(ALIGN_BYTES);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OFS_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_R_RD, S_R_WR, S_POST, S_F_WAIT, S_F_CHK,
    S_I_RD, S_I_CHK, S_I_SH, S_I_SW, S_I_DONE, S_RESP
  } state_t;
endpackage

/* sv/bfa_free_table.sv */
// Size-sorted free table memory with a registered read.
module bfa_free_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bfa_pkg::ADDR_W-1:0]  rd_addr,
  input  logic                        wr_en,
  input  logic [bfa_pkg::ADDR_W-1:0]  wr_addr,
  input  bfa_pkg::entry_t             wr_data,
  output bfa_pkg::entry_t             rd_data
);
  bfa_pkg::entry_t mem [bfa_pkg::FREE_ENTRIES];
  bfa_pkg::entry_t rd_q_r;
  logic            e0_init_r;
  logic            rd_init_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // entry 0 reads as the whole heap until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_init_r <= 1'b1;
      rd_init_r <= 1'b0;
    end else begin
      rd_init_r <= e0_init_r && (rd_addr == '0);
      if (wr_en && wr_addr == '0) begin
        e0_init_r <= 1'b0;
      end
    end
  end

  always_comb begin
    rd_data = rd_q_r;
    if (rd_init_r) begin
      rd_data.start = '0;
      rd_data.size  = bfa_pkg::SIZE_W'(bfa_pkg::HEAP_BYTES);
    end
  end
endmodule

/* sv/best_fit_block_allocator_unit.sv */
// Best-fit block allocator top level: control sequencer and block size store.
// One transaction in, one result out. Each operation walks the size-sorted
// free table in memory, one read or one write per cycle: a search reads
// entries in order until one fits, removal shifts the later entries down by
// one and insertion shifts the larger entries up by one, each move being a
// read and then a write. Requests that fail the argument checks go straight
// to the response state. The table's registered read port sets the pace of
// these walks. No clearing pass after reset.
`include "best_fit_block_allocator_unit_defines.svh"
module best_fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes[15:0], user_offset[31:16]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // granted_offset[15:0], status[17:16], bytes_left[34:18]
);
  localparam int OW = bfa_pkg::OFS_W;
  localparam int SW = bfa_pkg::SIZE_W;
  localparam int CW = bfa_pkg::CNT_W;
  localparam int AW = bfa_pkg::ADDR_W;

  bfa_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, pos_r, k_r;
  logic [SW-1:0] need_r, blk_size_r, ins_size_r, rem_r;
  logic [OW-1:0] blk_start_r, ins_start_r;
  logic          op_free_r;
  logic [1:0]    status_r;
  logic [OW-1:0] granted_r;

  logic          out_valid_r;
  logic [OW-1:0] out_granted_r;
  logic [1:0]    out_status_r;
  logic [SW-1:0] out_left_r;

  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  bfa_pkg::entry_t wr_data, rd_data;

  logic [bfa_pkg::SLOT_W-1:0] hs_addr;
  logic [SW-1:0] hs_mem [bfa_pkg::HEAP_BYTES / bfa_pkg::ALIGN_BYTES];
  logic [SW-1:0] hs_q_r;
  logic          hs_wr;

  logic          accept;
  logic [OW-1:0] req, ofs;
  logic [SW-1:0] need_c;
  logic [OW-1:0] fstart_c;
  logic          f_ok_c;
  logic          a_ok_c;
  logic          resp_go;
  logic          split_c;
  logic [SW-1:0] final_size_c;
  logic [SW:0]   fsum_c;

  assign in_tready = (state_r == bfa_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign req       = in_tdata[15:0];
  assign ofs       = in_tdata[31:16];
  assign need_c    = (SW'(req) + SW'(bfa_pkg::HEADER_BYTES + bfa_pkg::ALIGN_BYTES - 1))
                     & ~SW'(bfa_pkg::ALIGN_BYTES - 1);
  assign a_ok_c    = (req != '0) && (need_c < SW'(bfa_pkg::HEAP_BYTES));
  assign fstart_c  = ofs - OW'(bfa_pkg::HEADER_BYTES);
  assign f_ok_c    = (ofs >= OW'(bfa_pkg::HEADER_BYTES))
                     && (fstart_c[bfa_pkg::ALIGN_W-1:0] == '0)
                     && (SW'(fstart_c) < SW'(bfa_pkg::HEAP_BYTES));
  assign resp_go   = !out_valid_r || out_tready;
  assign split_c   = (blk_size_r - need_r)
                     > SW'(bfa_pkg::SPLIT_FACTOR * bfa_pkg::HEADER_BYTES);
  assign final_size_c = split_c ? need_r : blk_size_r;
  assign fsum_c    = {1'b0, rem_r} + {1'b0, ins_size_r};

  bfa_free_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign hs_addr = blk_start_r[OW-1:bfa_pkg::ALIGN_W];
  assign hs_wr   = (state_r == bfa_pkg::S_POST);

  always_ff @(posedge clk) begin
    if (hs_wr) begin
      hs_mem[hs_addr] <= final_size_c;
    end
    hs_q_r <= hs_mem[hs_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          if (in_tuser) begin
            state_nxt = f_ok_c ? bfa_pkg::S_F_WAIT : bfa_pkg::S_RESP;
          end else begin
            state_nxt = (a_ok_c && count_r != '0) ? bfa_pkg::S_A_RD : bfa_pkg::S_RESP;
          end
        end
      end
      bfa_pkg::S_A_RD:  state_nxt = bfa_pkg::S_A_CHK;
      bfa_pkg::S_A_CHK: begin
        if (rd_data.size >= need_r) begin
          state_nxt = bfa_pkg::S_R_RD;
        end else if (pos_r + CW'(1) == count_r) begin
          state_nxt = bfa_pkg::S_RESP;
        end else begin
          state_nxt = bfa_pkg::S_A_RD;
        end
      end
      bfa_pkg::S_R_RD:   state_nxt = (k_r + CW'(1) < count_r) ? bfa_pkg::S_R_WR
                                                              : bfa_pkg::S_POST;
      bfa_pkg::S_R_WR:   state_nxt = bfa_pkg::S_R_RD;
      bfa_pkg::S_POST:   state_nxt = split_c ? bfa_pkg::S_I_RD : bfa_pkg::S_RESP;
      bfa_pkg::S_F_WAIT: state_nxt = bfa_pkg::S_F_CHK;
      bfa_pkg::S_F_CHK:  state_nxt = (count_r >= CW'(bfa_pkg::FREE_ENTRIES))
                                     ? bfa_pkg::S_RESP : bfa_pkg::S_I_RD;
      bfa_pkg::S_I_RD:   state_nxt = (pos_r < count_r) ? bfa_pkg::S_I_CHK
                                                       : bfa_pkg::S_I_SH;
      bfa_pkg::S_I_CHK:  state_nxt = (rd_data.size < ins_size_r) ? bfa_pkg::S_I_RD
                                                                 : bfa_pkg::S_I_SH;
      bfa_pkg::S_I_SH:   state_nxt = (k_r > pos_r) ? bfa_pkg::S_I_SW : bfa_pkg::S_I_DONE;
      bfa_pkg::S_I_SW:   state_nxt = bfa_pkg::S_I_SH;
      bfa_pkg::S_I_DONE: state_nxt = bfa_pkg::S_RESP;
      bfa_pkg::S_RESP:   state_nxt = resp_go ? bfa_pkg::S_IDLE : bfa_pkg::S_RESP;
      default:           state_nxt = bfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = pos_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = k_r[AW-1:0];
    wr_data = rd_data;
    unique case (state_r)
      bfa_pkg::S_R_RD: rd_addr = AW'(k_r + CW'(1));
      bfa_pkg::S_R_WR: wr_en   = 1'b1;
      bfa_pkg::S_I_SH: begin
        rd_addr = AW'(k_r - CW'(1));
        if (k_r <= pos_r) begin
          wr_en         = 1'b1;
          wr_addr       = pos_r[AW-1:0];
          wr_data.start = ins_start_r;
          wr_data.size  = ins_size_r;
        end
      end
      bfa_pkg::S_I_SW: wr_en = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfa_pkg::S_IDLE;
      count_r <= CW'(1);
      rem_r   <= SW'(bfa_pkg::HEAP_BYTES);
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        bfa_pkg::S_IDLE: begin
          if (accept) begin
            op_free_r   <= in_tuser;
            need_r      <= need_c;
            blk_start_r <= fstart_c;
            ins_start_r <= fstart_c;
            pos_r       <= '0;
            status_r    <= bfa_pkg::ST_REJ;
            granted_r   <= '0;
          end
        end
        bfa_pkg::S_A_CHK: begin
          if (rd_data.size >= need_r) begin
            blk_start_r <= rd_data.start;
            blk_size_r  <= rd_data.size;
            k_r         <= pos_r;
          end else begin
            pos_r <= pos_r + CW'(1);
          end
        end
        bfa_pkg::S_R_RD: begin
          if (k_r + CW'(1) >= count_r) begin
            count_r <= count_r - CW'(1);
          end
        end
        bfa_pkg::S_R_WR: k_r <= k_r + CW'(1);
        bfa_pkg::S_POST: begin
          rem_r       <= (rem_r > final_size_c) ? rem_r - final_size_c : '0;
          granted_r   <= blk_start_r + OW'(bfa_pkg::HEADER_BYTES);
          status_r    <= bfa_pkg::ST_OK;
          ins_start_r <= blk_start_r + OW'(need_r);
          ins_size_r  <= blk_size_r - need_r;
          pos_r       <= '0;
        end
        bfa_pkg::S_F_CHK: begin
          ins_size_r <= hs_q_r;
          if (count_r >= CW'(bfa_pkg::FREE_ENTRIES)) begin
            status_r <= bfa_pkg::ST_FULL;
          end
        end
        bfa_pkg::S_I_RD: if (pos_r >= count_r) k_r <= count_r;
        bfa_pkg::S_I_CHK: begin
          if (rd_data.size < ins_size_r) begin
            pos_r <= pos_r + CW'(1);
          end else begin
            k_r <= count_r;
          end
        end
        bfa_pkg::S_I_SH: if (k_r <= pos_r) count_r <= count_r + CW'(1);
        bfa_pkg::S_I_SW: k_r <= k_r - CW'(1);
        bfa_pkg::S_I_DONE: begin
          if (op_free_r) begin
            status_r <= bfa_pkg::ST_OK;
            rem_r    <= (fsum_c > (SW+1)'(bfa_pkg::HEAP_BYTES))
                        ? SW'(bfa_pkg::HEAP_BYTES) : fsum_c[SW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == bfa_pkg::S_RESP && resp_go) begin
      out_valid_r   <= 1'b1;
      out_granted_r <= granted_r;
      out_status_r  <= status_r;
      out_left_r    <= rem_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_left_r, out_status_r, out_granted_r};

  `BFA_ASSERT(a_count_max, count_r <= CW'(bfa_pkg::FREE_ENTRIES))
  `BFA_ASSERT(a_left_max, out_tvalid |-> out_left_r <= SW'(bfa_pkg::HEAP_BYTES))
  `BFA_ASSERT_NEXT(a_busy_after_accept, accept, state_r != bfa_pkg::S_IDLE)
  `BFA_ASSERT(a_ok_full, (out_tvalid && out_status_r == bfa_pkg::ST_FULL) |-> out_granted_r == '0)
endmodule

/* bench/best_fit_block_allocator_unit_tb.sv */
// Self-checking testbench for the best-fit block allocator: directed and random allocate/free traffic.
`timescale 1ns / 1ps
module best_fit_block_allocator_unit_tb;
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam int   SLOTS     = bfa_pkg::HEAP_BYTES / bfa_pkg::ALIGN_BYTES;
  localparam int   MAX_WAIT  = 18;
  localparam int   CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        action;
    logic [15:0] request_bytes;
    logic [15:0] user_offset;
  } op_t;

  // first member sits in the top bits
  typedef struct packed {
    logic [16:0] bytes_left;
    logic [1:0]  status;
    logic [15:0] granted_offset;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  best_fit_block_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // allocator shadow state
  logic [15:0] blk_start [bfa_pkg::FREE_ENTRIES];
  logic [16:0] blk_size  [bfa_pkg::FREE_ENTRIES];
  int          blk_count;
  logic [16:0] slot_size [SLOTS];
  logic [16:0] free_bytes;
  logic [15:0] live_offsets[$];

  op_t    pending_ops[$];
  reply_t expected_replies[$];
  int     errors;
  int     cycles;
  int     n_alloc_ok, n_free_ok, n_full, n_rej;

  function automatic bit table_put(logic [15:0] start, logic [16:0] size);
    int pos;
    if (blk_count >= bfa_pkg::FREE_ENTRIES) return 0;
    pos = 0;
    while (pos < blk_count && blk_size[pos] < size) pos++;
    for (int k = blk_count; k > pos; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_size[k]  = blk_size[k-1];
    end
    blk_start[pos] = start;
    blk_size[pos]  = size;
    blk_count++;
    return 1;
  endfunction

  function automatic reply_t predict_allocator(op_t op);
    reply_t r;
    int need, pos, start, size;
    r = '0;
    r.status = bfa_pkg::ST_REJ;
    if (op.action == ACT_ALLOC) begin
      if (op.request_bytes != 0) begin
        need = op.request_bytes + bfa_pkg::HEADER_BYTES;
        need = (need + bfa_pkg::ALIGN_BYTES - 1) / bfa_pkg::ALIGN_BYTES * bfa_pkg::ALIGN_BYTES;
        if (need < bfa_pkg::HEAP_BYTES) begin
          pos = 0;
          while (pos < blk_count && blk_size[pos] < need) pos++;
          if (pos < blk_count) begin
            start = blk_start[pos];
            size  = blk_size[pos];
            for (int k = pos; k + 1 < blk_count; k++) begin
              blk_start[k] = blk_start[k+1];
              blk_size[k]  = blk_size[k+1];
            end
            blk_count--;
            if (size - need > bfa_pkg::SPLIT_FACTOR * bfa_pkg::HEADER_BYTES) begin
              void'(table_put(16'(start + need), 17'(size - need)));
              size = need;
            end
            slot_size[(start >> 3) % SLOTS] = 17'(size);
            free_bytes = (free_bytes > size) ? 17'(free_bytes - size) : '0;
            r.granted_offset = 16'(start + bfa_pkg::HEADER_BYTES);
            r.status = bfa_pkg::ST_OK;
          end
        end
      end
    end else if (op.user_offset >= bfa_pkg::HEADER_BYTES) begin
      start = op.user_offset - bfa_pkg::HEADER_BYTES;
      if (start % bfa_pkg::ALIGN_BYTES == 0 && start < bfa_pkg::HEAP_BYTES) begin
        size = slot_size[(start >> 3) % SLOTS];
        if (table_put(16'(start), 17'(size))) begin
          free_bytes = (free_bytes + size > bfa_pkg::HEAP_BYTES) ? 17'(bfa_pkg::HEAP_BYTES)
                                                                 : 17'(free_bytes + size);
          r.status = bfa_pkg::ST_OK;
        end else begin
          r.status = bfa_pkg::ST_FULL;
        end
      end
    end
    r.bytes_left = free_bytes;
    return r;
  endfunction

  // offsets whose header was written, so a free never reads an unwritten slot
  function automatic op_t pick_free();
    op_t op;
    int  idx;
    op = '0;
    op.action = ACT_FREE;
    case ($urandom_range(0, 9))
      0: op.user_offset = 16'($urandom_range(0, 15));           // null or below header
      1: op.user_offset = 16'($urandom_range(16, 65535) | 1);   // misaligned
      default: begin
        if (live_offsets.size() > 0) begin
          idx = $urandom_range(0, live_offsets.size() - 1);
          op.user_offset = live_offsets[idx];
          if ($urandom_range(0, 7) != 0) live_offsets.delete(idx); // else double free
        end else begin
          op.user_offset = 16'd0;
        end
      end
    endcase
    return op;
  endfunction

  task automatic queue_op(op_t op);
    reply_t r;
    r = predict_allocator(op);
    if (op.action == ACT_ALLOC && r.status == bfa_pkg::ST_OK) begin
      live_offsets.push_back(r.granted_offset);
    end
    pending_ops.push_back(op);
    expected_replies.push_back(r);
  endtask

  function automatic op_t mk_alloc(int bytes);
    op_t op;
    op = '0;
    op.action = ACT_ALLOC;
    op.request_bytes = 16'(bytes);
    op.user_offset = 16'($urandom());
    return op;
  endfunction

  int in_flight;
  always @(posedge clk) begin
    if (!rst_n) in_flight <= 0;
    else in_flight <= in_flight + (in_tvalid && in_tready) - (out_tvalid && out_tready);
  end

  // driver
  int  in_gap;
  bit  pause_req;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && !in_tready) begin
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap    <= in_gap - 1;
    end else if (pending_ops.size() > 0 && !(pause_req && in_flight > 0)) begin
      op_t op;
      op = pending_ops.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= op.action;
      in_tdata  <= {op.user_offset, op.request_bytes};
      in_gap    <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // monitor
  int out_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        reply_t got, exp;
        got = out_tdata[34:0];
        if (expected_replies.size() == 0) begin
          $error("unexpected transaction: %h", got);
          errors++;
        end else begin
          exp = expected_replies.pop_front();
          if (got.granted_offset !== exp.granted_offset) begin
            $error("granted_offset exp %0d got %0d", exp.granted_offset, got.granted_offset);
            errors++;
          end
          if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status);
            errors++;
          end
          if (got.bytes_left !== exp.bytes_left) begin
            $error("bytes_left exp %0d got %0d", exp.bytes_left, got.bytes_left);
            errors++;
          end
          case (exp.status)
            bfa_pkg::ST_OK:   if (exp.granted_offset != 0) n_alloc_ok++; else n_free_ok++;
            bfa_pkg::ST_FULL: n_full++;
            default: n_rej++;
          endcase
        end
      end
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap    <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && $urandom_range(0, 3) == 0) out_gap <= $urandom_range(0, MAX_WAIT);
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    op_t op;
    cycles = 0; errors = 0; pause_req = 0;
    n_alloc_ok = 0; n_free_ok = 0; n_full = 0; n_rej = 0;
    for (int i = 0; i < bfa_pkg::FREE_ENTRIES; i++) begin
      blk_start[i] = '0;
      blk_size[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) slot_size[i] = '0;
    blk_size[0] = 17'(bfa_pkg::HEAP_BYTES);
    blk_count = 1;
    free_bytes = 17'(bfa_pkg::HEAP_BYTES);
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    queue_op(mk_alloc(0));
    queue_op(mk_alloc(65535));
    queue_op(mk_alloc(bfa_pkg::HEAP_BYTES - bfa_pkg::HEADER_BYTES));
    queue_op(mk_alloc(bfa_pkg::HEAP_BYTES - bfa_pkg::HEADER_BYTES - 8));
    op = pick_free(); op.user_offset = 16'd0; queue_op(op);
    op.user_offset = 16'd8; queue_op(op);
    op.user_offset = 16'd17; queue_op(op);
    queue_op(mk_alloc(1));
    queue_op(mk_alloc(8));
    queue_op(mk_alloc(40));
    queue_op(mk_alloc(16'h5555));
    queue_op(mk_alloc(16'h2AAA));
    queue_op(mk_alloc(16'h7FFF));
    for (int i = 0; i < 4; i++) queue_op(pick_free());
    queue_op(mk_alloc(20000));
    queue_op(mk_alloc(20000));
    queue_op(mk_alloc(30000));
    // free of the block at the lowest user offset
    op = '0; op.action = ACT_FREE; op.user_offset = 16'(bfa_pkg::HEADER_BYTES);
    queue_op(op);

    // random: mostly small allocations, fragmenting the table until it fills
    for (int i = 0; i < 1400; i++) begin
      if (i == 700) begin
        wait (pending_ops.size() == 0);
        pause_req = 1;
        wait (expected_replies.size() == 0);
        pause_req = 0;
      end
      case ($urandom_range(0, 19))
        0:  queue_op(mk_alloc($urandom()));
        1:  queue_op(mk_alloc($urandom_range(40000, 65535)));
        2,3,4,5,6,7,8: queue_op(pick_free());
        default: queue_op(mk_alloc($urandom_range(1, 200)));
      endcase
    end
    wait (pending_ops.size() == 0 && expected_replies.size() == 0);
    repeat (600) @(posedge clk);
    $display("ran %0d cycles: %0d allocs ok, %0d frees ok, %0d table-full, %0d rejected",
             cycles, n_alloc_ok, n_free_ok, n_full, n_rej);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
